@@ src/fbtc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbtc_pkg
// Shared sizes, operation codes and transaction types for the text console.
// ----------------------------------------------------------------------------
`default_nettype none

package fbtc_pkg;

  // Frame and text geometry
  localparam int LINE_BYTES   = 64;
  localparam int PIXEL_LINES  = 64;
  localparam int TEXT_ROWS    = 8;
  localparam int TEXT_COLS    = 60;
  localparam int GLYPH_COUNT  = 256;
  localparam int CELL_LINES   = 8;

  localparam int FRAME_SIZE   = LINE_BYTES * PIXEL_LINES;
  localparam int GLYPH_SIZE   = GLYPH_COUNT * CELL_LINES;
  localparam int SCROLL_RAW   = CELL_LINES * LINE_BYTES;
  localparam int SCROLL_SHIFT = (SCROLL_RAW > FRAME_SIZE) ? FRAME_SIZE : SCROLL_RAW;
  localparam int COPY_LEN     = FRAME_SIZE - SCROLL_SHIFT;

  // Address and field widths
  localparam int FA_W   = $clog2(FRAME_SIZE);
  localparam int GA_W   = $clog2(GLYPH_SIZE);
  localparam int BCOL_W = $clog2(LINE_BYTES);
  localparam int LINE_W = $clog2(PIXEL_LINES);
  localparam int CL_W   = $clog2(CELL_LINES);
  localparam int ROW_W  = 3;
  localparam int COL_W  = 6;

  // Operation codes
  localparam logic [2:0] FUNC_PUT   = 3'd0;
  localparam logic [2:0] FUNC_PIXEL = 3'd1;
  localparam logic [2:0] FUNC_CLEAR = 3'd2;
  localparam logic [2:0] FUNC_FONT  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Control characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  char_code;
    logic [8:0]  pixel_x;
    logic [5:0]  pixel_y;
    logic [11:0] mem_addr;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
  } rsp_t;

  // Frame store access from the sequencer
  typedef struct packed {
    logic            we;
    logic [FA_W-1:0] waddr;
    logic [7:0]      wdata;
    logic [FA_W-1:0] raddr;
  } frame_port_t;

  // Glyph store access from the sequencer
  typedef struct packed {
    logic            we;
    logic [GA_W-1:0] waddr;
    logic [7:0]      wdata;
    logic [GA_W-1:0] raddr;
  } glyph_port_t;

endpackage

`default_nettype wire

@@ src/fbtc_ram.sv @@
// ----------------------------------------------------------------------------
// fbtc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/fbtc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbtc_ctrl
// Sequencer: decodes a transaction, drives the frame and glyph stores through
// read-modify-write steps and sweeps, and keeps the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module fbtc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire fbtc_pkg::req_t       req_i,
  output fbtc_pkg::rsp_t            rsp_o,
  output logic                      done_o,
  output fbtc_pkg::frame_port_t     frame_o,
  input  wire logic [7:0]           frame_rdata_i,
  output fbtc_pkg::glyph_port_t     glyph_o,
  input  wire logic [7:0]           glyph_rdata_i
);

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_CLEAR   = 8'b0000_0100,
    ST_DRAW    = 8'b0000_1000,
    ST_PIX     = 8'b0001_0000,
    ST_RD      = 8'b0010_0000,
    ST_SCR_CP  = 8'b0100_0000,
    ST_SCR_CLR = 8'b1000_0000
  } state_e;

  localparam logic [fbtc_pkg::FA_W-1:0] CNT_LAST  = fbtc_pkg::FA_W'(fbtc_pkg::FRAME_SIZE - 1);
  localparam logic [fbtc_pkg::FA_W-1:0] CNT_COPY  = fbtc_pkg::FA_W'(fbtc_pkg::COPY_LEN);
  localparam logic [fbtc_pkg::FA_W-1:0] CNT_SHIFT = fbtc_pkg::FA_W'(fbtc_pkg::SCROLL_SHIFT);
  localparam logic [fbtc_pkg::CL_W:0]   LINE_END  = (fbtc_pkg::CL_W + 1)'(fbtc_pkg::CELL_LINES);

  state_e                         state_q, state_d;
  logic [fbtc_pkg::FA_W-1:0]      cnt_q, cnt_d;
  logic [fbtc_pkg::CL_W:0]        line_q, line_d;
  logic [fbtc_pkg::ROW_W-1:0]     row_q, row_d;
  logic [fbtc_pkg::COL_W-1:0]     col_q, col_d;
  logic [7:0]                     code_q, code_d;
  logic [7:0]                     mask_q, mask_d;
  logic [fbtc_pkg::FA_W-1:0]      paddr_q, paddr_d;
  logic                           done_q, done_d;
  fbtc_pkg::rsp_t                 rsp_q, rsp_d;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      line_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      row_q   <= row_d;
      col_q   <= col_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    mask_q  <= mask_d;
    paddr_q <= paddr_d;
    rsp_q   <= rsp_d;
  end

  // Sequencer
  always_comb begin
    logic                          fin;
    logic [7:0]                    fin_data;
    logic [fbtc_pkg::ROW_W:0]      row_inc;
    logic [fbtc_pkg::COL_W:0]      col_inc;
    logic [fbtc_pkg::CL_W:0]       wk;
    logic [fbtc_pkg::LINE_W-1:0]   wline;
    logic [8:0]                    bcol;
    logic                          row_over;

    fin      = 1'b0;
    fin_data = '0;
    row_inc  = {1'b0, row_q} + 1'b1;
    col_inc  = {1'b0, col_q} + 1'b1;
    wk       = line_q - 1'b1;
    wline    = fbtc_pkg::LINE_W'({row_q, wk[fbtc_pkg::CL_W-1:0]});
    bcol     = req_i.pixel_x >> 3;
    row_over = (32'(row_inc) >= fbtc_pkg::TEXT_ROWS);

    state_d = state_q;
    cnt_d   = cnt_q;
    line_d  = line_q;
    row_d   = row_q;
    col_d   = col_q;
    code_d  = code_q;
    mask_d  = mask_q;
    paddr_d = paddr_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    frame_o = '0;
    glyph_o = '0;

    case (state_q)
      // Zero the frame store after reset
      ST_INIT: begin
        frame_o.we    = 1'b1;
        frame_o.waddr = cnt_q;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
        end
      end

      // Decode a new transaction
      ST_IDLE: begin
        if (start) begin
          case (req_i.func)
            fbtc_pkg::FUNC_PUT: begin
              if (req_i.char_code == fbtc_pkg::CHAR_CR) begin
                col_d = '0;
                fin   = 1'b1;
              end else if (req_i.char_code == fbtc_pkg::CHAR_LF) begin
                if (row_over) begin
                  row_d   = fbtc_pkg::ROW_W'(fbtc_pkg::TEXT_ROWS - 1);
                  cnt_d   = '0;
                  state_d = ST_SCR_CP;
                end else begin
                  row_d = row_inc[fbtc_pkg::ROW_W-1:0];
                  fin   = 1'b1;
                end
              end else begin
                code_d  = req_i.char_code;
                line_d  = '0;
                state_d = ST_DRAW;
              end
            end
            fbtc_pkg::FUNC_PIXEL: begin
              if (32'(bcol) < fbtc_pkg::LINE_BYTES &&
                  32'(req_i.pixel_y) < fbtc_pkg::PIXEL_LINES) begin
                paddr_d       = fbtc_pkg::FA_W'({req_i.pixel_y,
                                                 bcol[fbtc_pkg::BCOL_W-1:0]});
                frame_o.raddr = paddr_d;
                mask_d        = 8'd1 << req_i.pixel_x[2:0];
                state_d       = ST_PIX;
              end else begin
                fin = 1'b1;
              end
            end
            fbtc_pkg::FUNC_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            fbtc_pkg::FUNC_FONT: begin
              if (32'(req_i.mem_addr) < fbtc_pkg::GLYPH_SIZE) begin
                glyph_o.we    = 1'b1;
                glyph_o.waddr = req_i.mem_addr[fbtc_pkg::GA_W-1:0];
                glyph_o.wdata = req_i.write_byte;
              end
              fin = 1'b1;
            end
            fbtc_pkg::FUNC_READ: begin
              if (32'(req_i.mem_addr) < fbtc_pkg::FRAME_SIZE) begin
                frame_o.raddr = req_i.mem_addr[fbtc_pkg::FA_W-1:0];
                state_d       = ST_RD;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Clear screen sweep
      ST_CLEAR: begin
        frame_o.we    = 1'b1;
        frame_o.waddr = cnt_q;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
          fin     = 1'b1;
        end
      end

      // Copy glyph lines: read line k, write line k-1
      ST_DRAW: begin
        glyph_o.raddr = fbtc_pkg::GA_W'({code_q, line_q[fbtc_pkg::CL_W-1:0]});
        if (line_q != '0 &&
            32'({row_q, wk[fbtc_pkg::CL_W-1:0]}) < fbtc_pkg::PIXEL_LINES &&
            32'(col_q) < fbtc_pkg::LINE_BYTES) begin
          frame_o.we    = 1'b1;
          frame_o.waddr = fbtc_pkg::FA_W'({wline, col_q[fbtc_pkg::BCOL_W-1:0]});
          frame_o.wdata = (32'(code_q) < fbtc_pkg::GLYPH_COUNT) ? glyph_rdata_i : 8'd0;
        end
        line_d = line_q + 1'b1;
        if (line_q == LINE_END) begin
          state_d = ST_IDLE;
          if (32'(col_inc) >= fbtc_pkg::TEXT_COLS) begin
            col_d = '0;
            if (row_over) begin
              row_d   = fbtc_pkg::ROW_W'(fbtc_pkg::TEXT_ROWS - 1);
              cnt_d   = '0;
              state_d = ST_SCR_CP;
            end else begin
              row_d = row_inc[fbtc_pkg::ROW_W-1:0];
              fin   = 1'b1;
            end
          end else begin
            col_d = col_inc[fbtc_pkg::COL_W-1:0];
            fin   = 1'b1;
          end
        end
      end

      // Merge the pixel into the byte read last cycle
      ST_PIX: begin
        frame_o.we    = 1'b1;
        frame_o.waddr = paddr_q;
        frame_o.wdata = frame_rdata_i | mask_q;
        state_d       = ST_IDLE;
        fin           = 1'b1;
      end

      // Return the frame byte read last cycle
      ST_RD: begin
        fin_data = frame_rdata_i;
        state_d  = ST_IDLE;
        fin      = 1'b1;
      end

      // Scroll: read ahead by one cell row, write each byte in the cycle after its read
      ST_SCR_CP: begin
        frame_o.raddr = cnt_q + CNT_SHIFT;
        if (cnt_q != '0) begin
          frame_o.we    = 1'b1;
          frame_o.waddr = cnt_q - 1'b1;
          frame_o.wdata = frame_rdata_i;
        end
        if (cnt_q == CNT_COPY) begin
          state_d = ST_SCR_CLR;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Scroll: blank the freed lines
      ST_SCR_CLR: begin
        frame_o.we    = 1'b1;
        frame_o.waddr = cnt_q;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
          fin     = 1'b1;
        end
      end

      default: begin
        state_d = ST_INIT;
        cnt_d   = '0;
      end
    endcase

    // Load the result with the cursor after the operation
    if (fin) begin
      done_d           = 1'b1;
      rsp_d.read_data  = fin_data;
      rsp_d.cursor_row = row_d;
      rsp_d.cursor_col = col_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ src/framebuffer_text_console.sv @@
// ----------------------------------------------------------------------------
// framebuffer_text_console
// Text console over a 512x64-pixel monochrome frame store with a loadable 8x8
// font.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result shows
// on rsp_o for one cycle with done_o high, and cannot be held off. After reset
// busy stays high while the frame store is zeroed. Font load, CR, LF without
// scroll and unused codes are answered from idle; set pixel and frame read take
// one store read, then one write or return; a printable character takes eight
// glyph reads piped into eight frame writes; clear screen writes one frame byte
// per cycle. A scroll copies the frame up by one text row, one byte read and
// one written per cycle, then blanks the bottom text row.
`default_nettype none

module framebuffer_text_console (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire fbtc_pkg::req_t req_i,
  output fbtc_pkg::rsp_t      rsp_o,
  output logic                done_o
);

  fbtc_pkg::frame_port_t frame_port;
  fbtc_pkg::glyph_port_t glyph_port;
  logic [7:0]            frame_rdata;
  logic [7:0]            glyph_rdata;

  // Sequencer
  fbtc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .done_o        (done_o),
    .frame_o       (frame_port),
    .frame_rdata_i (frame_rdata),
    .glyph_o       (glyph_port),
    .glyph_rdata_i (glyph_rdata)
  );

  // Frame store
  fbtc_ram #(
    .WIDTH (8),
    .DEPTH (fbtc_pkg::FRAME_SIZE)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_port.we),
    .waddr_i (frame_port.waddr),
    .wdata_i (frame_port.wdata),
    .raddr_i (frame_port.raddr),
    .rdata_o (frame_rdata)
  );

  // Glyph store
  fbtc_ram #(
    .WIDTH (8),
    .DEPTH (fbtc_pkg::GLYPH_SIZE)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_port.we),
    .waddr_i (glyph_port.waddr),
    .wdata_i (glyph_port.wdata),
    .raddr_i (glyph_port.raddr),
    .rdata_o (glyph_rdata)
  );

  // An accepted transaction either answers next cycle or keeps the block busy
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither answered nor busy");

  // A result is only given once the sequencer is back to idle
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Reported cursor stays inside the text grid
  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(rsp_o.cursor_col) < fbtc_pkg::TEXT_COLS &&
                32'(rsp_o.cursor_row) < fbtc_pkg::TEXT_ROWS))
    else $error("cursor outside text grid");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console: drives put-character, set-pixel,
// clear, font-load and frame-read transactions, predicts every result from its
// own model of the frame store, glyph store and cursor, and compares each
// strobed result with the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

  // Spare operation codes, expected to leave all state alone
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Worst case: every transaction scrolls, plus the clearing pass after reset,
  // taken a few times over
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  fbtc_pkg::req_t req_d = '0;
  logic busy;
  logic done_o;
  fbtc_pkg::rsp_t rsp_q;

  // Console model state
  bit [7:0]   frame_mem [fbtc_pkg::FRAME_SIZE];
  bit [7:0]   font_mem [fbtc_pkg::GLYPH_SIZE];
  bit         font_set [fbtc_pkg::GLYPH_SIZE];
  bit         glyph_ready [fbtc_pkg::GLYPH_COUNT];
  logic [7:0] ready_glyphs [$];
  int unsigned cur_row;
  int unsigned cur_col;

  fbtc_pkg::rsp_t expected_rsp [$];
  int   err_count;
  int   live_count;
  int   cycle_count;
  bit   idle_en;

  framebuffer_text_console dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_d),
    .rsp_o  (rsp_q),
    .done_o (done_o)
  );

  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL framebuffer_text_console");
      $finish;
    end
  end

  // Move the cursor down one text row, scrolling the frame at the bottom
  function automatic void next_row();
    cur_row++;
    if (cur_row >= fbtc_pkg::TEXT_ROWS) begin
      cur_row = fbtc_pkg::TEXT_ROWS - 1;
      for (int i = 0; i < fbtc_pkg::COPY_LEN; i++)
        frame_mem[i] = frame_mem[i + fbtc_pkg::SCROLL_SHIFT];
      for (int i = fbtc_pkg::COPY_LEN; i < fbtc_pkg::FRAME_SIZE; i++) frame_mem[i] = '0;
    end
  endfunction

  // Apply one transaction to the console model and return its result
  function automatic fbtc_pkg::rsp_t console_step(fbtc_pkg::req_t item);
    fbtc_pkg::rsp_t res;
    int unsigned line;
    int unsigned bcol;
    int unsigned g;
    bit          complete;
    res = '0;
    case (item.func)
      fbtc_pkg::FUNC_PUT: begin
        if (item.char_code == fbtc_pkg::CHAR_CR) begin
          cur_col = 0;
        end else if (item.char_code == fbtc_pkg::CHAR_LF) begin
          next_row();
        end else begin
          for (int i = 0; i < fbtc_pkg::CELL_LINES; i++) begin
            line = cur_row * fbtc_pkg::CELL_LINES + i;
            if (line < fbtc_pkg::PIXEL_LINES && cur_col < fbtc_pkg::LINE_BYTES)
              frame_mem[line * fbtc_pkg::LINE_BYTES + cur_col] =
                font_mem[item.char_code * fbtc_pkg::CELL_LINES + i];
          end
          cur_col++;
          if (cur_col >= fbtc_pkg::TEXT_COLS) begin
            cur_col = 0;
            next_row();
          end
        end
      end
      fbtc_pkg::FUNC_PIXEL: begin
        bcol = item.pixel_x >> 3;
        if (bcol < fbtc_pkg::LINE_BYTES && item.pixel_y < fbtc_pkg::PIXEL_LINES)
          frame_mem[item.pixel_y * fbtc_pkg::LINE_BYTES + bcol] |=
            8'(1 << item.pixel_x[2:0]);
      end
      fbtc_pkg::FUNC_CLEAR: begin
        foreach (frame_mem[k]) frame_mem[k] = '0;
        cur_row = 0;
        cur_col = 0;
      end
      fbtc_pkg::FUNC_FONT: begin
        if (item.mem_addr < fbtc_pkg::GLYPH_SIZE) begin
          font_mem[item.mem_addr] = item.write_byte;
          font_set[item.mem_addr] = 1'b1;
          // Offer a glyph for printing once all its lines are loaded
          g = item.mem_addr / fbtc_pkg::CELL_LINES;
          complete = 1'b1;
          for (int i = 0; i < fbtc_pkg::CELL_LINES; i++)
            complete &= font_set[g * fbtc_pkg::CELL_LINES + i];
          if (complete && !glyph_ready[g] && g != fbtc_pkg::CHAR_CR &&
              g != fbtc_pkg::CHAR_LF) begin
            glyph_ready[g] = 1'b1;
            ready_glyphs.push_back(8'(g));
          end
        end
      end
      fbtc_pkg::FUNC_READ: begin
        if (item.mem_addr < fbtc_pkg::FRAME_SIZE) res.read_data = frame_mem[item.mem_addr];
      end
      default: ;
    endcase
    res.cursor_row = fbtc_pkg::ROW_W'(cur_row);
    res.cursor_col = fbtc_pkg::COL_W'(cur_col);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Check each strobed result against the oldest prediction
  always @(negedge clk_i) begin
    fbtc_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        flag_error($sformatf("unexpected result %p", rsp_q));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_q.read_data !== want.read_data || rsp_q.cursor_row !== want.cursor_row ||
            rsp_q.cursor_col !== want.cursor_col)
          flag_error($sformatf("exp data %02h row %0d col %0d, got data %02h row %0d col %0d",
                               want.read_data, want.cursor_row, want.cursor_col,
                               rsp_q.read_data, rsp_q.cursor_row, rsp_q.cursor_col));
      end
    end
  end

  // Send one transaction, with an optional idle burst ahead of it
  task automatic send_item(input fbtc_pkg::req_t item);
    bit hit;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_d <= item;
    do begin
      @(negedge clk_i);
      hit = !busy;
      @(posedge clk_i);
    end while (!hit);
    expected_rsp.push_back(console_step(item));
    if (!(item.func > fbtc_pkg::FUNC_READ ||
          (item.func == fbtc_pkg::FUNC_FONT && item.mem_addr >= fbtc_pkg::GLYPH_SIZE)))
      live_count++;
  endtask

  // Random content in every field, operation set by the caller
  function automatic fbtc_pkg::req_t make_item(input logic [2:0] func);
    fbtc_pkg::req_t item;
    item = $bits(fbtc_pkg::req_t)'({$urandom, $urandom});
    item.func = func;
    return item;
  endfunction

  function automatic fbtc_pkg::req_t char_item(input logic [7:0] code);
    fbtc_pkg::req_t item;
    item = make_item(fbtc_pkg::FUNC_PUT);
    item.char_code = code;
    return item;
  endfunction

  function automatic fbtc_pkg::req_t addr_item(input logic [2:0] func,
                                               input int unsigned addr);
    fbtc_pkg::req_t item;
    item = make_item(func);
    item.mem_addr = 12'(addr);
    return item;
  endfunction

  function automatic fbtc_pkg::req_t pixel_item(input int unsigned x, input int unsigned y);
    fbtc_pkg::req_t item;
    item = make_item(fbtc_pkg::FUNC_PIXEL);
    item.pixel_x = 9'(x);
    item.pixel_y = 6'(y);
    return item;
  endfunction

  task automatic test_font_load();
    logic [7:0] pattern [fbtc_pkg::CELL_LINES] =
      '{8'hFF, 8'h81, 8'h42, 8'h24, 8'h18, 8'h00, 8'hAA, 8'h55};
    fbtc_pkg::req_t item;
    for (int i = 0; i < fbtc_pkg::CELL_LINES; i++) begin
      item = addr_item(fbtc_pkg::FUNC_FONT, 8'hFF * fbtc_pkg::CELL_LINES + i);
      item.write_byte = pattern[i];
      send_item(item);
    end
    // Ignore a write past the glyph store
    send_item(addr_item(fbtc_pkg::FUNC_FONT, 12'hFFF));
  endtask

  task automatic test_put_char();
    send_item(char_item(8'hFF));
    send_item(addr_item(fbtc_pkg::FUNC_READ, 0));
    send_item(char_item(fbtc_pkg::CHAR_CR));
  endtask

  task automatic test_pixel_read();
    send_item(pixel_item(511, 63));
    send_item(pixel_item(9, 0));
    send_item(addr_item(fbtc_pkg::FUNC_READ, fbtc_pkg::FRAME_SIZE - 1));
    send_item(make_item(FUNC_SPARE_HI));
  endtask

  task automatic test_scroll();
    // Walk down every row; the last line feed scrolls the frame
    for (int i = 0; i < fbtc_pkg::TEXT_ROWS; i++) send_item(char_item(fbtc_pkg::CHAR_LF));
    send_item(addr_item(fbtc_pkg::FUNC_READ, 0));
  endtask

  task automatic test_clear();
    send_item(make_item(fbtc_pkg::FUNC_CLEAR));
  endtask

  // Mostly text lines with random content, mixed with pixel, font, read bursts
  task automatic test_random_traffic(input int n, input bit allow_idle);
    int   target;
    int   kind;
    int   len;
    int   r;
    fbtc_pkg::req_t item;
    target = live_count + n;
    while (live_count < target) begin
      idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = $urandom_range(1, 70);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 5) send_item(char_item(fbtc_pkg::CHAR_LF));
          else if (r < 9) send_item(char_item(fbtc_pkg::CHAR_CR));
          else send_item(char_item(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]));
        end
        if ($urandom_range(0, 1) == 0) begin
          send_item(char_item(fbtc_pkg::CHAR_CR));
          send_item(char_item(fbtc_pkg::CHAR_LF));
        end
      end else if (kind < 65) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0)
            send_item(pixel_item($urandom_range(0, 1) * 511, $urandom_range(0, 1) * 63));
          else
            send_item(make_item(fbtc_pkg::FUNC_PIXEL));
        end
      end else if (kind < 78) begin
        r = $urandom_range(0, fbtc_pkg::GLYPH_COUNT - 1);
        for (int i = 0; i < fbtc_pkg::CELL_LINES; i++)
          send_item(addr_item(fbtc_pkg::FUNC_FONT, r * fbtc_pkg::CELL_LINES + i));
      end else if (kind < 93) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          // Aim half the reads at the cursor's text row
          if ($urandom_range(0, 1) == 0)
            send_item(addr_item(fbtc_pkg::FUNC_READ,
                                (cur_row * fbtc_pkg::CELL_LINES + $urandom_range(0, 7)) *
                                fbtc_pkg::LINE_BYTES +
                                $urandom_range(0, fbtc_pkg::LINE_BYTES - 1)));
          else
            send_item(make_item(fbtc_pkg::FUNC_READ));
        end
      end else if (kind < 98) begin
        if ($urandom_range(0, 1) == 0)
          send_item(make_item(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI))));
        else
          send_item(make_item(fbtc_pkg::FUNC_FONT));
      end else begin
        send_item(make_item(fbtc_pkg::FUNC_CLEAR));
      end
    end
  endtask

  // Back-to-back traffic with no idle cycles
  task automatic test_streaming();
    test_random_traffic(60, 1'b0);
  endtask

  initial begin
    idle_en = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_font_load();
    test_put_char();
    test_pixel_read();
    test_scroll();
    test_clear();
    test_random_traffic(350, 1'b1);
    test_streaming();

    // Drain outstanding results
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0 && expected_rsp.size() == 0) begin
      $display("PASS framebuffer_text_console");
    end else begin
      $display("FAIL framebuffer_text_console");
    end
    $finish;
  end

endmodule
